// ===== src/base64_name_decoder_filter_assert.svh =====
// -----------------------------------------------------------------------------
// Base64 name decoder assertion macros
// Shared concurrent assertion helpers, clocked on clk_i and disabled in reset.
// -----------------------------------------------------------------------------
`ifndef BASE64_NAME_DECODER_FILTER_ASSERT_SVH
`define BASE64_NAME_DECODER_FILTER_ASSERT_SVH

// Assert an implication on every rising edge of clk_i outside reset.
`define B64ND_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Assert a next-cycle implication on every rising edge of clk_i outside reset.
`define B64ND_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/b64nd_pkg.sv =====
// -----------------------------------------------------------------------------
// Base64 name decoder package
// Shared types, character constants and helper functions.
// -----------------------------------------------------------------------------
`default_nettype none

package b64nd_pkg;

  localparam int unsigned NumSlots = 3;

  localparam logic [7:0] CharUpperA  = 8'h41;
  localparam logic [7:0] CharUpperZ  = 8'h5A;
  localparam logic [7:0] CharLowerA  = 8'h61;
  localparam logic [7:0] CharLowerZ  = 8'h7A;
  localparam logic [7:0] CharZero    = 8'h30;
  localparam logic [7:0] CharNine    = 8'h39;
  localparam logic [7:0] CharPlus    = 8'h2B;
  localparam logic [7:0] CharSlash   = 8'h2F;
  localparam logic [7:0] CharPad     = 8'h3D;
  localparam logic [7:0] CharBslash  = 8'h5C;
  localparam logic [7:0] PrintLow    = 8'h20;
  localparam logic [7:0] PrintHigh   = 8'h7E;

  localparam logic [5:0] SextetLowerBase = 6'd26;
  localparam logic [5:0] SextetDigitBase = 6'd52;
  localparam logic [5:0] SextetPlus      = 6'd62;
  localparam logic [5:0] SextetSlash     = 6'd63;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_BAD_CHAR = 2'd1,
    ERR_LENGTH   = 2'd2,
    ERR_PAD      = 2'd3
  } err_e;

  typedef struct packed {
    logic       bad;
    logic       pad;
    logic [5:0] sextet;
  } class_t;

  // Per-name decoder state
  typedef struct packed {
    logic [17:0] acc;
    logic [1:0]  pos;
    logic [1:0]  pad;
    err_e        err;
  } state_t;

  // Results caused by one character: up to three bytes plus end-of-name info
  typedef struct packed {
    logic [NumSlots-1:0]      mask;
    logic [NumSlots-1:0][7:0] bytes;
    logic                     last;
    err_e                     err;
  } pack_t;

  function automatic class_t classify(input logic [7:0] c);
    class_t r;
    r = '{bad: 1'b0, pad: 1'b0, sextet: 6'd0};
    if (c >= CharUpperA && c <= CharUpperZ) begin
      r.sextet = 6'(c - CharUpperA);
    end else if (c >= CharLowerA && c <= CharLowerZ) begin
      r.sextet = 6'(c - CharLowerA) + SextetLowerBase;
    end else if (c >= CharZero && c <= CharNine) begin
      r.sextet = 6'(c - CharZero) + SextetDigitBase;
    end else if (c == CharPlus) begin
      r.sextet = SextetPlus;
    end else if (c == CharSlash) begin
      r.sextet = SextetSlash;
    end else if (c == CharPad) begin
      r.pad = 1'b1;
    end else begin
      r.bad = 1'b1;
    end
    return r;
  endfunction

  function automatic logic byte_kept(input logic [7:0] b, input logic filter_en);
    logic keep;
    keep = 1'b1;
    if (filter_en) begin
      keep = (b >= PrintLow) && (b <= PrintHigh) && (b != CharSlash) && (b != CharBslash);
    end
    return keep;
  endfunction

endpackage

`default_nettype wire

// ===== src/b64nd_in_if.sv =====
// -----------------------------------------------------------------------------
// Base64 name decoder input channel
// Valid/ready channel carrying one encoded character and its last flag.
// -----------------------------------------------------------------------------
`default_nettype none

interface b64nd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       in_last;

  modport source (output valid, output in_char, output in_last, input ready);
  modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

`default_nettype wire

// ===== src/b64nd_out_if.sv =====
// -----------------------------------------------------------------------------
// Base64 name decoder output channel
// Valid/ready channel carrying one decoded byte or an end-of-name marker.
// -----------------------------------------------------------------------------
`default_nettype none

interface b64nd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       end_of_name;
  logic [1:0] error_code;

  modport source (output valid, output out_byte, output byte_valid, output end_of_name,
                  output error_code, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input end_of_name,
                  input error_code, output ready);
endinterface

`default_nettype wire

// ===== src/b64nd_decode.sv =====
// -----------------------------------------------------------------------------
// Base64 name decoder character step
// Classifies one character, advances the group state, builds the result pack.
// -----------------------------------------------------------------------------
`default_nettype none

module b64nd_decode (
  input  var b64nd_pkg::state_t state_i,
  input  wire logic [7:0]       char_i,
  input  wire logic             last_i,
  input  wire logic             filter_en_i,
  output b64nd_pkg::state_t     state_o,
  output b64nd_pkg::pack_t      pack_o
);

  b64nd_pkg::class_t cls;
  b64nd_pkg::err_e   err_d;
  logic [5:0]        sextet;
  logic [1:0]        pad_d;
  logic [23:0]       word;
  logic [1:0]        nbytes;
  logic [1:0]        pos_d;

  always_comb begin
    cls    = b64nd_pkg::classify(char_i);
    err_d  = state_i.err;
    sextet = cls.sextet;
    pad_d  = state_i.pad;
    word   = {state_i.acc, cls.sextet};
    nbytes = 2'd0;
    pos_d  = state_i.pos;
    pack_o = '0;
    state_o = state_i;

    if (state_i.err == b64nd_pkg::ERR_NONE) begin
      if (cls.bad) begin
        err_d = b64nd_pkg::ERR_BAD_CHAR;
      end else if (cls.pad) begin
        if (state_i.pos < 2'd2) begin
          err_d = b64nd_pkg::ERR_PAD;
        end else begin
          pad_d  = state_i.pad + 2'd1;
          sextet = 6'd0;
        end
      end else if (state_i.pad != 2'd0) begin
        err_d = b64nd_pkg::ERR_PAD;
      end
    end

    word = {state_i.acc, sextet};
    state_o.pad = pad_d;
    state_o.err = err_d;

    if (state_i.err == b64nd_pkg::ERR_NONE && err_d == b64nd_pkg::ERR_NONE) begin
      if (state_i.pos == 2'd3) begin
        nbytes = (pad_d > 2'd2) ? 2'd1 : 2'd3 - pad_d;
        pack_o.bytes[0] = word[23:16];
        pack_o.bytes[1] = word[15:8];
        pack_o.bytes[2] = word[7:0];
        for (int k = 0; k < b64nd_pkg::NumSlots; k++) begin
          pack_o.mask[k] = (2'(k) < nbytes) &&
                           b64nd_pkg::byte_kept(pack_o.bytes[k], filter_en_i);
        end
        state_o.acc = '0;
      end else begin
        state_o.acc = word[17:0];
      end
      pos_d = state_i.pos + 2'd1;
      state_o.pos = pos_d;
    end

    if (last_i) begin
      pack_o.last = 1'b1;
      pack_o.err  = (err_d == b64nd_pkg::ERR_NONE && pos_d != 2'd0) ?
                    b64nd_pkg::ERR_LENGTH : err_d;
      state_o     = '{acc: '0, pos: 2'd0, pad: 2'd0, err: b64nd_pkg::ERR_NONE};
    end
  end

endmodule

`default_nettype wire

// ===== src/b64nd_outbuf.sv =====
// -----------------------------------------------------------------------------
// Base64 name decoder result buffer
// Holds one result pack and drains it one request per cycle while the output is ready.
// -----------------------------------------------------------------------------
`default_nettype none

`include "base64_name_decoder_filter_assert.svh"

module b64nd_outbuf (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  var b64nd_pkg::pack_t  pack_i,
  output logic                  ready_o,
  b64nd_out_if.source           out_o
);

  logic [2:0]      mask_q, mask_d;
  logic [2:0][7:0] bytes_q;
  logic            last_q;
  b64nd_pkg::err_e err_q;
  logic            empty_q, empty_d;

  logic       busy;
  logic       final_one;
  logic       pop;
  logic [1:0] idx;
  logic [2:0] low_bit;

  always_comb begin
    busy    = (mask_q != 3'd0) || empty_q;
    idx     = mask_q[0] ? 2'd0 : (mask_q[1] ? 2'd1 : 2'd2);
    low_bit = mask_q & ~(mask_q - 3'd1);
    final_one = (mask_q == 3'd0) ? empty_q : ((mask_q & (mask_q - 3'd1)) == 3'd0);
    pop     = out_o.valid && out_o.ready;
    ready_o = !busy || (pop && final_one);

    out_o.valid       = busy;
    out_o.byte_valid  = (mask_q != 3'd0);
    out_o.out_byte    = (mask_q != 3'd0) ? bytes_q[idx] : 8'd0;
    out_o.end_of_name = last_q && final_one;
    out_o.error_code  = (last_q && final_one) ? err_q : b64nd_pkg::ERR_NONE;

    // Advance: retire the current request, then take a new pack if offered
    mask_d  = mask_q;
    empty_d = empty_q;
    if (pop) begin
      if (mask_q != 3'd0) begin
        mask_d = mask_q & ~low_bit;
      end else begin
        empty_d = 1'b0;
      end
    end
    if (load_i) begin
      mask_d  = pack_i.mask;
      empty_d = pack_i.last && (pack_i.mask == 3'd0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q  <= 3'd0;
      empty_q <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      mask_q  <= mask_d;
      empty_q <= empty_d;
      if (load_i) begin
        last_q <= pack_i.last;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bytes_q <= pack_i.bytes;
      err_q   <= pack_i.err;
    end
  end

  `B64ND_ASSERT_IMPL(a_marker_ends_name, out_o.valid && !out_o.byte_valid, out_o.end_of_name, "empty request without end of name")
  `B64ND_ASSERT_IMPL(a_err_only_at_end, out_o.valid && !out_o.end_of_name, out_o.error_code == b64nd_pkg::ERR_NONE, "error code on a non-final request")
  `B64ND_ASSERT_NEXT(a_drain_continues, pop && !final_one, out_o.valid, "pack lost its remaining requests")
  `B64ND_ASSERT_IMPL(a_load_when_free, load_i, !busy || (pop && final_one), "pack overwritten while requests pending")

endmodule

`default_nettype wire

// ===== src/base64_name_decoder_filter.sv =====
// A character passes the input register, then the result pack, before its first result request.
// Throughput: 1 character per cycle while the output channel is ready; a character that
//   completes a group with 2 or 3 kept bytes holds the input while the result pack drains.
// Reset: asynchronous, active low; clears the group state, empties both stages and
//   sets filter_enable to 1.
// -----------------------------------------------------------------------------
// Base64 name decoder with output filter
// Decodes a base64 encoded name one character at a time and emits the kept bytes,
// closing each name with an end-of-name request that carries its error code.
// -----------------------------------------------------------------------------
`default_nettype none

module base64_name_decoder_filter (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   cfg_we_i,
  input  wire logic   cfg_data_i,
  b64nd_in_if.sink    in_i,
  b64nd_out_if.source out_o
);

  // Input register: one character waiting for the decode step
  logic       inq_valid_q;
  logic [7:0] inq_char_q;
  logic       inq_last_q;

  // Filter enable register: the user must write it only while the block is idle; the block does not enforce this
  logic filter_en_q;

  // Group state: sextet accumulator, position, padding count, first error
  b64nd_pkg::state_t state_q, state_d;
  b64nd_pkg::pack_t  pack;

  logic buf_ready;
  logic advance;
  logic in_take;

  // Move the held character into the result pack when the buffer can take it
  assign advance    = inq_valid_q && buf_ready;
  assign in_i.ready = !inq_valid_q || advance;
  assign in_take    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
      filter_en_q <= 1'b1;
      state_q     <= '{acc: '0, pos: 2'd0, pad: 2'd0, err: b64nd_pkg::ERR_NONE};
    end else begin
      if (cfg_we_i) begin
        filter_en_q <= cfg_data_i;
      end
      // Hold the character until it advances, then refill from the input
      if (in_take) begin
        inq_valid_q <= 1'b1;
      end else if (advance) begin
        inq_valid_q <= 1'b0;
      end
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  // Payload of the input register needs no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      inq_char_q <= in_i.in_char;
      inq_last_q <= in_i.in_last;
    end
  end

  // Classify the character, update the group and build up to three results
  b64nd_decode u_decode (
    .state_i     (state_q),
    .char_i      (inq_char_q),
    .last_i      (inq_last_q),
    .filter_en_i (filter_en_q),
    .state_o     (state_d),
    .pack_o      (pack)
  );

  // Result pack, drained one request per cycle on the output channel while it is ready
  b64nd_outbuf u_outbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance),
    .pack_i  (pack),
    .ready_o (buf_ready),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

// ===== tb/b64nd_checker.sv =====
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// Base64 name decoder result checker
// Watches both channels and the filter register writes. Decodes every accepted
// character on its own, queues the bytes it should produce, and compares each
// output request against the oldest queued byte.
// -----------------------------------------------------------------------------

module b64nd_checker (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  cfg_we_i,
  input  logic  cfg_data_i,
  b64nd_in_if   in_mon,
  b64nd_out_if  out_mon,
  output int    mismatches_o,
  output int    pending_o,
  output int    live_chars_o
);
  import b64nd_pkg::*;

  localparam logic [6:0] SymPad = 7'd64;
  localparam logic [6:0] SymBad = 7'd65;

  typedef struct packed {
    logic [7:0] data;
    logic       kept;
    logic       eon;
    err_e       err;
  } name_byte_t;

  name_byte_t  exp_bytes[$];
  name_byte_t  got_res;
  name_byte_t  want_res;

  logic        filter_on;
  logic [17:0] acc;
  logic [1:0]  slot;
  logic [1:0]  pads;
  err_e        name_err;

  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    if (c >= CharUpperA && c <= CharUpperZ) return 7'(c - CharUpperA);
    if (c >= CharLowerA && c <= CharLowerZ) return 7'(c - CharLowerA) + 7'(SextetLowerBase);
    if (c >= CharZero && c <= CharNine) return 7'(c - CharZero) + 7'(SextetDigitBase);
    if (c == CharPlus) return 7'(SextetPlus);
    if (c == CharSlash) return 7'(SextetSlash);
    if (c == CharPad) return SymPad;
    return SymBad;
  endfunction

  function automatic logic keeps(input logic [7:0] b, input logic filt);
    if (!filt) return 1'b1;
    if (b < PrintLow || b > PrintHigh) return 1'b0;
    return (b != CharSlash) && (b != CharBslash);
  endfunction

  // Advance the name state by one character and queue the bytes it yields.
  task automatic decode_char(input logic [7:0] c, input logic last);
    name_byte_t  res [3];
    int          n;
    int          nb;
    logic [6:0]  sym;
    logic [5:0]  s;
    logic [23:0] word;
    logic [7:0]  b;
    n = 0;
    if (name_err == ERR_NONE) begin
      live_chars_o++;
      sym = sextet_of(c);
      s   = sym[5:0];
      if (sym == SymBad) begin
        name_err = ERR_BAD_CHAR;
      end else if (sym == SymPad) begin
        if (slot < 2'd2) begin
          name_err = ERR_PAD;
        end else begin
          pads = pads + 2'd1;
          s    = '0;
        end
      end else if (pads != 2'd0) begin
        name_err = ERR_PAD;
      end

      if (name_err == ERR_NONE) begin
        if (slot == 2'd3) begin
          word = {acc, s};
          nb   = (pads > 2'd2) ? 1 : 3 - int'(pads);
          for (int k = 0; k < nb; k++) begin
            b = word[23 - 8 * k -: 8];
            if (keeps(b, filter_on)) begin
              res[n] = '{data: b, kept: 1'b1, eon: 1'b0, err: ERR_NONE};
              n++;
            end
          end
          acc = '0;
        end else begin
          acc = {acc[11:0], s};
        end
        slot = slot + 2'd1;
      end
    end

    if (last) begin
      if (name_err == ERR_NONE && slot != 2'd0) name_err = ERR_LENGTH;
      if (n == 0) begin
        res[0] = '{data: 8'h00, kept: 1'b0, eon: 1'b0, err: ERR_NONE};
        n = 1;
      end
      res[n-1].eon = 1'b1;
      res[n-1].err = name_err;
      acc      = '0;
      slot     = '0;
      pads     = '0;
      name_err = ERR_NONE;
    end

    for (int k = 0; k < n; k++) exp_bytes.push_back(res[k]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_bytes.delete();
      filter_on    = 1'b1;
      acc          = '0;
      slot         = '0;
      pads         = '0;
      name_err     = ERR_NONE;
      mismatches_o = 0;
      live_chars_o = 0;
      pending_o    = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got_res = '{data: out_mon.out_byte, kept: out_mon.byte_valid,
                    eon: out_mon.end_of_name, err: err_e'(out_mon.error_code)};
        if (exp_bytes.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= 10)
            $display("%0t: unexpected result: byte %h valid %b end %b err %0d", $realtime,
                     got_res.data, got_res.kept, got_res.eon, got_res.err);
        end else begin
          want_res = exp_bytes.pop_front();
          if (got_res !== want_res) begin
            mismatches_o++;
            if (mismatches_o <= 10)
              $display("%0t: wrong result: expected byte %h valid %b end %b err %0d, got byte %h valid %b end %b err %0d",
                       $realtime, want_res.data, want_res.kept, want_res.eon, want_res.err,
                       got_res.data, got_res.kept, got_res.eon, got_res.err);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) decode_char(in_mon.in_char, in_mon.in_last);
      if (cfg_we_i) filter_on = cfg_data_i;
      pending_o = exp_bytes.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// Base64 name decoder testbench
// Feeds encoded names to the decoder: a short directed set of corner cases,
// then random well-formed, broken and noise names across both filter settings,
// with random idling on both channels. The checker decides each result.
// -----------------------------------------------------------------------------

module tb_top;
  import b64nd_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we;
  logic cfg_data;
  bit   calm;           // when set, neither side idles
  int   mismatches;
  int   pending;
  int   live_chars;

  b64nd_in_if  in_ch ();
  b64nd_out_if out_ch ();

  base64_name_decoder_filter uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  b64nd_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_data_i   (cfg_data),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .live_chars_o (live_chars)
  );

  always #2 clk_i = ~clk_i;

  // Stop a hung run; the slowest correct run needs a small fraction of this.
  initial begin : watchdog
    #2_000_000;
    $display("base64_name_decoder_filter: mismatch");
    $finish;
  end

  // Map a sextet to its alphabet character.
  function automatic logic [7:0] b64_symbol(input logic [5:0] v);
    if (v < SextetLowerBase) return CharUpperA + 8'(v);
    if (v < SextetDigitBase) return CharLowerA + 8'(v - SextetLowerBase);
    if (v < SextetPlus) return CharZero + 8'(v - SextetDigitBase);
    if (v == SextetPlus) return CharPlus;
    return CharSlash;
  endfunction

  // Offer one character after a random gap and hold it until the request is taken.
  // Lower valid only when a gap follows, so a back-to-back request keeps it high.
  task automatic send_char(input logic [7:0] c, input logic last);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_char <= c;
    in_ch.in_last <= last;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  // Hold the input until every queued result has drained, then let the pipeline
  // settle, since characters that yield nothing may still be in flight.
  task automatic drain_input();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (8) @(posedge clk_i);
  endtask

  // Write the filter register while the block is idle.
  task automatic set_filter(input logic v);
    drain_input();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  // Build one random name: mostly well-formed encodings of biased bytes, some
  // broken on purpose, and a few of plain noise.
  task automatic send_random_name();
    logic [7:0]  chars[$];
    logic [7:0]  raw[$];
    logic [7:0]  b;
    logic [23:0] word;
    int          kind;
    int          nbytes;
    int          idx;
    int          len;
    kind = $urandom_range(0, 9);
    if (kind <= 7) begin
      nbytes = $urandom_range(1, 9);
      for (int i = 0; i < nbytes; i++) begin
        // Bias toward the bytes the filter cares about.
        case ($urandom_range(0, 7))
          0: b = CharSlash;
          1: b = CharBslash;
          2: b = $urandom_range(0, 1) ? 8'($urandom_range(0, 31)) : 8'($urandom_range(127, 255));
          3: begin
            case ($urandom_range(0, 5))
              0: b = 8'h00;
              1: b = 8'hFF;
              2: b = PrintLow;
              3: b = PrintHigh;
              4: b = PrintLow - 8'd1;
              default: b = PrintHigh + 8'd1;
            endcase
          end
          4, 5: b = 8'($urandom_range(PrintLow, PrintHigh));
          default: b = 8'($urandom_range(0, 255));
        endcase
        raw.push_back(b);
      end
      // Encode three bytes per group, padding the last group.
      for (int g = 0; g < nbytes; g += 3) begin
        word = {raw[g], (g + 1 < nbytes) ? raw[g+1] : 8'h00, (g + 2 < nbytes) ? raw[g+2] : 8'h00};
        chars.push_back(b64_symbol(word[23:18]));
        chars.push_back(b64_symbol(word[17:12]));
        chars.push_back((g + 1 < nbytes) ? b64_symbol(word[11:6]) : CharPad);
        chars.push_back((g + 2 < nbytes) ? b64_symbol(word[5:0]) : CharPad);
      end
      if (kind >= 6) begin
        idx = $urandom_range(0, chars.size() - 1);
        case ($urandom_range(0, 3))
          0: begin
            len = $urandom_range(1, chars.size() - 1);
            chars = chars[0:len-1];
          end
          1: chars[idx] = 8'($urandom_range(0, 255));
          2: chars.insert(idx, CharPad);
          default: chars.push_back(b64_symbol(6'($urandom_range(0, 63))));
        endcase
      end
    end else begin
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(0, 3))
          0, 1: chars.push_back(8'($urandom_range(0, 255)));
          2: chars.push_back(CharPad);
          default: chars.push_back(b64_symbol(6'($urandom_range(0, 63))));
        endcase
      end
    end
    foreach (chars[i]) send_char(chars[i], i == chars.size() - 1);
  endtask

  // Output side: stall a random number of cycles before taking each request.
  initial begin : sink_side
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (out_ch.valid !== 1'b1);
    end
  end

  initial begin : stimulus
    int  start_live;
    int  next_phase;
    bit  phase_filter;
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_data      = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.in_char = 8'h00;
    in_ch.in_last = 1'b0;
    calm          = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed names, filter on from reset.
    send_text("QUJD");      // three printable bytes
    send_text("L1w=");      // slash and backslash dropped, one pad
    send_text("=");         // pad in the first position
    send_text("Q=");        // pad in the second position
    send_text("Q");         // name ends inside a group
    send_text("*A");        // bad character, then an ignored one
    send_text("Zg==Q");     // data in the group after padding
    send_char(8'hFF, 1'b1); // top character code, not in the alphabet

    // Filter off: every decoded byte passes, including the extremes.
    set_filter(1'b0);
    send_text("////");

    // Random phases, toggling the filter and picking the idling at random between them.
    phase_filter = 1'b0;
    start_live   = live_chars;
    next_phase   = live_chars + 75;
    while (live_chars - start_live < 450) begin
      if (live_chars >= next_phase) begin
        phase_filter = ~phase_filter;
        set_filter(phase_filter);
        calm       = ($urandom_range(0, 3) == 0);
        next_phase = next_phase + 75;
      end
      // Now and then hold off until the output side has caught up.
      if ($urandom_range(0, 39) == 0) drain_input();
      send_random_name();
    end

    drain_input();
    repeat (12) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("base64_name_decoder_filter: match");
    end else begin
      $display("base64_name_decoder_filter: mismatch");
    end
    $finish;
  end

endmodule
